@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the LCD refresh scanner.
// No dependencies; simulation sees the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, muted while reset is high.
`define LBRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, live during reset too.
`define LBRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBRS_ASSERT(lbl, clk, rst, prop, msg)
`define LBRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/lbrs_pkg.sv @@
// Package for the LCD refresh scanner: beat payload types and display constants.
// No dependencies.
`default_nettype none
package lbrs_pkg;

  // Input beat: store request or refresh tick.
  typedef struct packed {
    logic       func;
    logic [3:0] column;
    logic       line;
    logic [7:0] char_code;
  } lbrs_in_t;

  // Output beat: one nibble toward the display.
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } lbrs_out_t;

  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_REFRESH = 1'b1;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [7:0] CURSOR_CMD = 8'h80;
  localparam logic [7:0] ROW_STRIDE = 8'h40;
  localparam logic [7:0] HIGH_MASK  = 8'hF0;
  localparam logic [7:0] LOW_MASK   = 8'h0F;

endpackage
`default_nettype wire

@@ src/lbrs_if.sv @@
// Valid/ready channel interfaces of the LCD refresh scanner.
// Depends on lbrs_pkg for the payload types.
`default_nettype none
interface lbrs_in_if;
  import lbrs_pkg::*;
  logic     valid;
  logic     ready;
  lbrs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbrs_out_if;
  import lbrs_pkg::*;
  logic      valid;
  logic      ready;
  lbrs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/lcd_buffer_refresh_scanner.sv @@
// LCD refresh scanner top level: frame memory, scan pointer, nibble serializer.
// Depends on lbrs_pkg, lbrs_if, lbrs_frame_mem and assert_macros.svh.
//
// Use: host carries beats of {func, column, line, char_code}. func = store
// writes char_code into the frame at (column, line); out-of-range stores are
// dropped. func = refresh emits one byte on lcd as two beats, high nibble
// (last = 0) then low nibble (last = 1), both with the same rs. A refresh
// sends the character under the scan pointer (rs = 1) and steps the column;
// once the column has passed the end it sends the cursor command for the next
// row (rs = 0), wrapping after the last row.
// Flow: a taken refresh fills the pending stage, then moves on to the output
// slot that drives lcd. A refresh may be taken while the last byte is still in
// the output slot; the refresh rate is set by the two nibble beats per byte on
// lcd. The frame memory read issued at accept lands in the pending stage, so a
// store followed at once by a refresh of the same cell reads the new code.
// Reset: frame reads as all zero (per-entry valid flops, cleared by reset),
// scan pointer at column 0 row 0, no beat pending.
// Stall: while lcd is held, one byte waits in the output slot and one more in
// the pending stage; host.ready then drops until the slot frees.
`default_nettype none
`include "assert_macros.svh"
module lcd_buffer_refresh_scanner #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input logic        clk,
  input logic        rst,
  lbrs_in_if.sink    host,
  lbrs_out_if.source lcd
);
  import lbrs_pkg::*;

  localparam int DEPTH  = COLUMNS * ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = $clog2(COLUMNS + 1);

  // scan pointer
  logic [COL_W-1:0] scan_col;
  logic             scan_row;

  // pending stage: byte waiting for the memory read or holding a command
  logic       s1_vld;
  logic       s1_rs;
  logic [7:0] s1_cmd;

  // output slot: byte being sent, phase 0 = high nibble, 1 = low nibble
  logic       o_vld;
  logic       o_phase;
  logic       o_rs;
  logic [7:0] o_byte;

  logic              accept;
  logic              refresh;
  logic              store_ok;
  logic [ADDR_W-1:0] st_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              s1_adv;
  logic              at_end;
  logic              row_next;

  assign s1_adv     = s1_vld && (!o_vld || (o_phase && lcd.ready));
  assign host.ready = !s1_vld || s1_adv;
  assign accept     = host.valid && host.ready;
  assign refresh    = accept && (host.data.func == FUNC_REFRESH);

  assign store_ok = accept && (host.data.func == FUNC_STORE)
                    && (int'(host.data.column) < COLUMNS)
                    && (int'(host.data.line) < ROWS);
  assign st_addr  = ADDR_W'(int'(host.data.line) * COLUMNS + int'(host.data.column));
  assign rd_addr  = ADDR_W'(int'(scan_row) * COLUMNS + int'(scan_col));

  assign at_end   = (scan_col >= COL_W'(COLUMNS));
  assign row_next = (scan_row == 1'(ROWS - 1)) ? 1'b0 : ~scan_row;

  lbrs_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_ok),
    .wr_addr (st_addr),
    .wr_data (host.data.char_code),
    .rd_en   (refresh && !at_end),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_row <= 1'b0;
      s1_vld   <= 1'b0;
      o_vld    <= 1'b0;
      o_phase  <= 1'b0;
    end else begin
      if (refresh) begin
        if (at_end) begin
          scan_col <= '0;
          scan_row <= row_next;
        end else begin
          scan_col <= scan_col + 1'b1;
        end
      end

      if (refresh) begin
        s1_vld <= 1'b1;
      end else if (s1_adv) begin
        s1_vld <= 1'b0;
      end

      if (s1_adv) begin
        o_vld   <= 1'b1;
        o_phase <= 1'b0;
      end else if (o_vld && lcd.ready) begin
        if (!o_phase) begin
          o_phase <= 1'b1;
        end else begin
          o_vld <= 1'b0;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (refresh) begin
      s1_rs  <= at_end ? RS_CMD : RS_DATA;
      s1_cmd <= CURSOR_CMD | (row_next ? ROW_STRIDE : 8'h00);
    end
    if (s1_adv) begin
      o_rs   <= s1_rs;
      o_byte <= (s1_rs == RS_DATA) ? rd_data : s1_cmd;
    end
  end

  assign lcd.valid       = o_vld;
  assign lcd.data.rs     = o_rs;
  assign lcd.data.nibble = o_phase ? 4'(o_byte & LOW_MASK) : 4'((o_byte & HIGH_MASK) >> 4);
  assign lcd.data.last   = o_phase;

  // high nibble taken -> low nibble of the same byte is offered next
  `LBRS_ASSERT(a_low_follows, clk, rst, (lcd.valid && lcd.ready && !lcd.data.last) |=> (lcd.valid && lcd.data.last), "low nibble missing after high nibble")
  `LBRS_ASSERT(a_rs_kept, clk, rst, (lcd.valid && lcd.ready && !lcd.data.last) |=> (lcd.data.rs == $past(lcd.data.rs)), "rs changed within a byte")
  `LBRS_ASSERT(a_col_range, clk, rst, scan_col <= COL_W'(COLUMNS), "scan column past end")
  `LBRS_ASSERT(a_backpressure, clk, rst, (s1_vld && !s1_adv) |-> !host.ready, "host taken while pending byte blocked")

endmodule
`default_nettype wire

@@ src/lbrs_frame_mem.sv @@
// Character frame memory: one write port, one registered read port.
// Per-entry valid flops make unwritten entries read as zero after reset.
`default_nettype none
module lbrs_frame_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : 8'h00;

endmodule
`default_nettype wire
